### design/b2da_pkg.sv
// shared types and constants for the binary to decimal ascii printer
// no dependencies; imported by b2da_cell, b2da_chain and the top level
package b2da_pkg;

	// width of the number that is converted (low bits of the input field)
	localparam int VALUE_WIDTH = 32;
	// width of the input field itself
	localparam int IN_WIDTH    = 32;
	localparam int CHAR_WIDTH  = 7;
	localparam int BCD_W       = 4;

	localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'h30;
	localparam logic [CHAR_WIDTH-1:0] ASCII_SPACE = 7'h20;
	localparam logic [BCD_W-1:0]      BCD_NINE    = 4'd9;
	localparam logic [BCD_W-1:0]      BCD_FIVE    = 4'd5;
	localparam logic [BCD_W-1:0]      BCD_THREE   = 4'd3;

	// number of decimal digits of the largest value of the given width
	function automatic int calc_digits(input int w);
		longint unsigned v;
		int n;
		begin
			v = (64'd1 << w) - 64'd1;
			n = 0;
			for (int i = 0; i < 20; i++) begin
				if (v != 0) begin
					n = n + 1;
					v = v / 10;
				end
			end
			return n;
		end
	endfunction

	localparam int NUM_DIGITS = calc_digits(VALUE_WIDTH);
	localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	// control for every cell of the digit row
	typedef struct packed {
		logic clear;       // zero all digits
		logic shift_bit;   // add-3 adjust and shift one binary bit in
		logic shift_digit; // move each digit one cell towards the top
	} cell_ctl_t;

endpackage

### design/b2da_cell.sv
// one bcd digit cell of the double-dabble row
// depends on b2da_pkg
module b2da_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  b2da_pkg::cell_ctl_t       ctl,
	input  logic                      bit_in,
	input  logic [b2da_pkg::BCD_W-1:0] digit_in,
	output logic                      bit_out,
	output logic [b2da_pkg::BCD_W-1:0] digit
);
	import b2da_pkg::*;

	logic [BCD_W-1:0] digit_q;
	logic [BCD_W-1:0] adj;

	// add three when the digit would overflow after doubling
	always_comb begin
		adj = (digit_q >= BCD_FIVE) ? digit_q + BCD_THREE : digit_q;
	end

	assign bit_out = adj[BCD_W-1];
	assign digit   = digit_q;

	// digit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.shift_bit) begin
			digit_q <= {adj[BCD_W-2:0], bit_in};
		end else if (ctl.shift_digit) begin
			digit_q <= digit_in;
		end
	end

endmodule

### design/b2da_chain.sv
// row of bcd digit cells, least significant digit at index 0
// depends on b2da_pkg and b2da_cell
module b2da_chain (
	input  logic                      clk,
	input  logic                      arst_n,
	input  b2da_pkg::cell_ctl_t       ctl,
	input  logic                      bit_in,
	output logic [b2da_pkg::BCD_W-1:0] top_digit
);
	import b2da_pkg::*;

	logic             carry [NUM_DIGITS+1];
	logic [BCD_W-1:0] dig   [NUM_DIGITS];
	logic [BCD_W-1:0] below [NUM_DIGITS];

	assign carry[0] = bit_in;

	// each cell takes the bit and the digit of its lower neighbour
	for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign below[g] = '0;
		end else begin : g_rest
			assign below[g] = dig[g-1];
		end
		b2da_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.bit_in   (carry[g]),
			.digit_in (below[g]),
			.bit_out  (carry[g+1]),
			.digit    (dig[g])
		);
	end

	assign top_digit = dig[NUM_DIGITS-1];

	// the row is sized so that no bit ever leaves the top cell
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift_bit |-> !carry[NUM_DIGITS])
		else $error("digit row overflow");

endmodule

### design/binary_to_decimal_ascii_top.sv
// top level of the binary to decimal ascii printer: control and output register
// depends on b2da_pkg and b2da_chain
//
// usage
// - input channel: value with in_valid / in_ready; an item is taken when both
//   are high. in_ready is high only while the block is idle, one item at a time.
// - output channel: char_code and last with out_valid / out_ready. each item
//   gives its decimal digits, most significant first with no leading zeros
//   (zero gives one '0'), then a space with last high.
// - timing: after acceptance the value is shifted into a row of ten bcd digit
//   cells, one bit per cycle until all bits of the value are in. the row then
//   moves one digit per cycle towards the top cell, which is printed or, while
//   it is a leading zero, skipped; a printed digit waits for a free output
//   register. then the space is loaded; in_ready returns in the cycle after
//   the space is loaded, so the block takes a new value only once the space
//   of the last one is loaded.
// - a stalled receiver holds the output register; the digit row waits with it.
//   the next item may be taken while the final space still waits to be taken.
// - reset clears the control state and drops out_valid; no clearing pass.
module binary_to_decimal_ascii_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [b2da_pkg::IN_WIDTH-1:0]   value,
	input  logic                            in_valid,
	output logic                            in_ready,
	output logic [b2da_pkg::CHAR_WIDTH-1:0] char_code,
	output logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready
);
	import b2da_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_left_q;
	logic                   started_q;
	logic [CHAR_WIDTH-1:0]  char_q;
	logic                   last_q;
	logic                   out_valid_q;

	cell_ctl_t              ctl;
	logic [BCD_W-1:0]       top_digit;
	logic                   in_fire;
	logic                   slot_free;
	logic                   show;
	logic                   emit_digit;
	logic                   emit_space;
	logic                   skip_digit;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// digit selection while printing
	always_comb begin
		show       = started_q || (top_digit != '0) || (dig_left_q == DIG_CNT_W'(1));
		emit_digit = (state_q == ST_EMIT) && (dig_left_q != '0) && show && slot_free;
		skip_digit = (state_q == ST_EMIT) && (dig_left_q != '0) && !show;
		emit_space = (state_q == ST_EMIT) && (dig_left_q == '0) && slot_free;
	end

	// row control
	always_comb begin
		ctl.clear       = in_fire;
		ctl.shift_bit   = (state_q == ST_CONV);
		ctl.shift_digit = emit_digit || skip_digit;
	end

	b2da_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.bit_in    (value_q[VALUE_WIDTH-1]),
		.top_digit (top_digit)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bit_cnt_q  <= '0;
			dig_left_q <= '0;
			started_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						bit_cnt_q <= BIT_CNT_W'(VALUE_WIDTH);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
					if (bit_cnt_q == BIT_CNT_W'(1)) begin
						dig_left_q <= DIG_CNT_W'(NUM_DIGITS);
						started_q  <= 1'b0;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_digit || skip_digit) begin
						dig_left_q <= dig_left_q - DIG_CNT_W'(1);
					end
					if (emit_digit) begin
						started_q <= 1'b1;
					end
					if (emit_space) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// value shift register, most significant bit first into the row
	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_q <= value[VALUE_WIDTH-1:0];
		end else if (state_q == ST_CONV) begin
			value_q <= {value_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_digit || emit_space) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_digit) begin
			char_q <= ASCII_ZERO + {{(CHAR_WIDTH-BCD_W){1'b0}}, top_digit};
			last_q <= 1'b0;
		end else if (emit_space) begin
			char_q <= ASCII_SPACE;
			last_q <= 1'b1;
		end
	end

	assign char_code = char_q;
	assign last      = last_q;
	assign out_valid = out_valid_q;

	// a printed digit is always a decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && dig_left_q != '0) |-> (top_digit <= BCD_NINE))
		else $error("digit cell holds a non-decimal value");

	// digit items carry digit codes, the closing item the space
	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (char_code >= ASCII_ZERO &&
			char_code <= ASCII_ZERO + 7'd9))
		else $error("digit item with a non-digit code");

	a_space_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> (char_code == ASCII_SPACE))
		else $error("last item is not a space");

	// only one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken while an item is in work");

endmodule
